// ===== hw/rtl/mbbs_pkg.sv =====
// Shared constants, types and sequencer codes for the mesh bounding box and sphere block.
package mbbs_pkg;

  localparam int COORD_BITS = 24;
  localparam int WIDE_BITS  = COORD_BITS + 1;
  localparam int ROOT_BITS  = WIDE_BITS;
  localparam int SUM_BITS   = 2 * ROOT_BITS;
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int REM_BITS   = ROOT_BITS + 1;
  localparam int CNT_BITS   = $clog2(ROOT_BITS);
  localparam int NUM_AXES   = 3;

  localparam int IN_FIELD_BITS  = NUM_AXES * COORD_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = NUM_AXES * COORD_BITS + NUM_AXES * WIDE_BITS + ROOT_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        extent_t;
  typedef logic signed [WIDE_BITS-1:0]  center_t;
  typedef logic [ROOT_BITS-1:0]         root_t;
  typedef logic [SUM_BITS-1:0]          sum_t;
  typedef logic [PROD_BITS-1:0]         prod_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    BND_HOLD,
    BND_WIDEN,
    BND_CLEAR
  } bnd_op_t;

  typedef struct packed {
    bnd_op_t op;
    axis_t   axis;
  } bnd_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIDEN,
    ST_MEASURE,
    ST_SQUARE,
    ST_ADD,
    ST_LOAD,
    ST_ROOT,
    ST_OUT
  } state_t;

endpackage

// ===== hw/rtl/mesh_bounding_box_sphere.sv =====
// Top level: vertex stream in, bounding box extents, centers and sphere radius out.
// A vertex without the last mark is accepted, then widened on each axis in turn.
// After a last vertex is accepted, the sequencer widens and measures each axis, squares
// and adds each extent through the one multiplier, loads the root unit and forms the root;
// then m_tvalid rises. Input is not ready until that result has been taken; the min and max
// registers are restored for the next mesh as the result is formed. Reset is synchronous.
module mesh_bounding_box_sphere (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0 up: coord_x, coord_y, coord_z.
  input  logic [mbbs_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // last_vertex.
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // Fields from bit 0 up: extent_x, extent_y, extent_z, center_x, center_y, center_z,
  // sphere_radius.
  output logic [mbbs_pkg::OUT_DATA_BITS-1:0]  m_tdata
);
  import mbbs_pkg::*;

  state_t   state;
  state_t   state_next;
  axis_t    axis;
  coord_t   vtx [NUM_AXES];
  logic     vtx_last;
  extent_t  ext [NUM_AXES];
  center_t  ctr [NUM_AXES];
  prod_t    prod;
  sum_t     sum;
  bnd_cmd_t cmd;
  coord_t   coord_sel;
  extent_t  ext_sel;
  extent_t  extent;
  center_t  center;
  logic     root_start;
  root_t    root;
  logic     root_done;
  logic     accept;

  function automatic axis_t step_axis(input axis_t a);
    return (a == AXIS_Z) ? AXIS_X : a + axis_t'(1);
  endfunction

  assign accept = s_tvalid && s_tready;

  always_comb begin
    case (axis)
      AXIS_Y: begin
        coord_sel = vtx[1];
        ext_sel   = ext[1];
      end
      AXIS_Z: begin
        coord_sel = vtx[2];
        ext_sel   = ext[2];
      end
      default: begin
        coord_sel = vtx[0];
        ext_sel   = ext[0];
      end
    endcase
  end

  mbbs_bounds u_bounds (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .coord  (coord_sel),
    .extent (extent),
    .center (center)
  );

  mbbs_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (sum),
    .root  (root),
    .done  (root_done)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_WIDEN;
        end
      end
      ST_WIDEN: begin
        if (axis == AXIS_Z) begin
          state_next = vtx_last ? ST_MEASURE : ST_IDLE;
        end
      end
      ST_MEASURE: begin
        if (axis == AXIS_Z) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: state_next = ST_ADD;
      ST_ADD: begin
        state_next = (axis == AXIS_Z) ? ST_LOAD : ST_SQUARE;
      end
      ST_LOAD: state_next = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    root_start = 1'b0;
    cmd.op     = BND_HOLD;
    cmd.axis   = axis;
    case (state)
      ST_IDLE:    s_tready = 1'b1;
      ST_WIDEN:   cmd.op = BND_WIDEN;
      ST_MEASURE: begin
        // The last axis read also restores the bounds for the next mesh.
        if (axis == AXIS_Z) begin
          cmd.op = BND_CLEAR;
        end
      end
      ST_LOAD:    root_start = 1'b1;
      ST_OUT:     m_tvalid = 1'b1;
      default:    cmd.op = BND_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= AXIS_X;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          axis <= AXIS_X;
          if (accept) begin
            vtx[0]   <= s_tdata[COORD_BITS-1:0];
            vtx[1]   <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            vtx[2]   <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
            vtx_last <= s_tlast;
          end
        end
        ST_WIDEN: axis <= step_axis(axis);
        ST_MEASURE: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            if (axis == axis_t'(i)) begin
              ext[i] <= extent;
              ctr[i] <= center;
            end
          end
          sum  <= '0;
          axis <= step_axis(axis);
        end
        ST_SQUARE: prod <= ext_sel * ext_sel;
        ST_ADD: begin
          sum  <= sum + sum_t'(prod);
          axis <= step_axis(axis);
        end
        default: axis <= axis;
      endcase
    end
  end

  assign m_tdata = OUT_DATA_BITS'({root, ctr[2], ctr[1], ctr[0], ext[2], ext[1], ext[0]});

endmodule

// ===== hw/rtl/mbbs_bounds.sv =====
// Per-axis running minimum and maximum with one shared compare and add unit.
module mbbs_bounds (
  input  logic              clk,
  input  logic              rst,
  input  mbbs_pkg::bnd_cmd_t cmd,
  input  mbbs_pkg::coord_t  coord,
  output mbbs_pkg::extent_t extent,
  output mbbs_pkg::center_t center
);
  import mbbs_pkg::*;

  coord_t low  [NUM_AXES];
  coord_t high [NUM_AXES];
  coord_t low_sel;
  coord_t high_sel;
  logic   below;
  logic   above;

  always_comb begin
    case (cmd.axis)
      AXIS_Y: begin
        low_sel  = low[1];
        high_sel = high[1];
      end
      AXIS_Z: begin
        low_sel  = low[2];
        high_sel = high[2];
      end
      default: begin
        low_sel  = low[0];
        high_sel = high[0];
      end
    endcase
  end

  assign below  = coord < low_sel;
  assign above  = coord > high_sel;
  assign extent = extent_t'(high_sel - low_sel);
  assign center = center_t'(high_sel) + center_t'(low_sel);

  // A clear command still shows the selected axis on extent and center in its cycle.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (rst || cmd.op == BND_CLEAR) begin
        low[i]  <= COORD_MAX;
        high[i] <= COORD_MIN;
      end else if (cmd.op == BND_WIDEN && cmd.axis == axis_t'(i)) begin
        if (below) begin
          low[i] <= coord;
        end
        if (above) begin
          high[i] <= coord;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/mbbs_root.sv =====
// Iterative integer square root, one result bit per cycle.
module mbbs_root (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mbbs_pkg::sum_t  value,
  output mbbs_pkg::root_t root,
  output logic            done
);
  import mbbs_pkg::*;

  sum_t                 rest;
  logic [REM_BITS-1:0]  rem;
  logic                 active;
  logic [CNT_BITS-1:0]  count;
  logic [REM_BITS+1:0]  trial;
  logic [REM_BITS+1:0]  test;
  logic                 fits;
  logic [REM_BITS+1:0]  diff;

  // Bring down the next two bits and try root*4 + 1 against the partial remainder.
  assign trial = {rem, rest[SUM_BITS-1 -: 2]};
  assign test  = {1'b0, root, 2'b01};
  assign fits  = trial >= test;
  assign diff  = trial - test;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count  <= '0;
        rest   <= value;
        rem    <= '0;
        root   <= '0;
      end else if (active) begin
        rest <= {rest[SUM_BITS-3:0], 2'b00};
        rem  <= fits ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
        root <= {root[ROOT_BITS-2:0], fits};
        count <= count + CNT_BITS'(1);
        if (count == CNT_BITS'(ROOT_BITS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== tb/tb_mesh_bounding_box_sphere.sv =====
// Self-checking testbench for the mesh bounding box and sphere block with a predicting scoreboard.
module tb_mesh_bounding_box_sphere;
  import mbbs_pkg::*;

  localparam int PAD_BITS = OUT_DATA_BITS - OUT_FIELD_BITS;
  localparam int RANDOM_VERTICES = 550;

  // Result item as it lies in m_tdata, highest field first.
  typedef struct packed {
    logic [PAD_BITS-1:0] pad;
    root_t               radius;
    center_t             center_z;
    center_t             center_y;
    center_t             center_x;
    extent_t             extent_z;
    extent_t             extent_y;
    extent_t             extent_x;
  } box_result_t;

  class bbox_scoreboard;
    coord_t      low_x, low_y, low_z;
    coord_t      high_x, high_y, high_z;
    box_result_t boxes_due[$];
    int          errors;

    function new();
      errors = 0;
      clear_bounds();
    endfunction

    function void clear_bounds();
      low_x  = COORD_MAX;
      low_y  = COORD_MAX;
      low_z  = COORD_MAX;
      high_x = COORD_MIN;
      high_y = COORD_MIN;
      high_z = COORD_MIN;
    endfunction

    // Digit-by-digit integer square root, floored.
    function root_t floor_root(logic [63:0] value);
      logic [63:0] remaining;
      logic [63:0] root;
      logic [63:0] probe;
      remaining = value;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > remaining) probe = probe >> 2;
      while (probe != 0) begin
        if (remaining >= root + probe) begin
          remaining = remaining - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root_t'(root);
    endfunction

    function void note_vertex(coord_t x, coord_t y, coord_t z, logic last);
      box_result_t box;
      logic [63:0] ex, ey, ez;
      if (x < low_x) low_x = x;
      if (x > high_x) high_x = x;
      if (y < low_y) low_y = y;
      if (y > high_y) high_y = y;
      if (z < low_z) low_z = z;
      if (z > high_z) high_z = z;
      if (!last) return;
      box = '0;
      box.extent_x = extent_t'(high_x - low_x);
      box.extent_y = extent_t'(high_y - low_y);
      box.extent_z = extent_t'(high_z - low_z);
      box.center_x = {high_x[COORD_BITS-1], high_x} + {low_x[COORD_BITS-1], low_x};
      box.center_y = {high_y[COORD_BITS-1], high_y} + {low_y[COORD_BITS-1], low_y};
      box.center_z = {high_z[COORD_BITS-1], high_z} + {low_z[COORD_BITS-1], low_z};
      ex = 64'(box.extent_x);
      ey = 64'(box.extent_y);
      ez = 64'(box.extent_z);
      box.radius = floor_root(ex * ex + ey * ey + ez * ez);
      boxes_due.push_back(box);
      clear_bounds();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_box(logic [OUT_DATA_BITS-1:0] data);
      box_result_t got;
      box_result_t want;
      got = data;
      if (boxes_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, got 0x%0h", $time, data);
        return;
      end
      want = boxes_due.pop_front();
      compare_field("extent_x", 64'(want.extent_x), 64'(got.extent_x));
      compare_field("extent_y", 64'(want.extent_y), 64'(got.extent_y));
      compare_field("extent_z", 64'(want.extent_z), 64'(got.extent_z));
      compare_field("center_x", 64'(want.center_x), 64'(got.center_x));
      compare_field("center_y", 64'(want.center_y), 64'(got.center_y));
      compare_field("center_z", 64'(want.center_z), 64'(got.center_z));
      compare_field("sphere_radius", 64'(want.radius), 64'(got.radius));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;
  logic                     s_tlast = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned take_stall_pct = 0;
  int          vertices_sent = 0;

  bbox_scoreboard board = new();

  mesh_bounding_box_sphere u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // The clock starts low so that the first rising edge comes after time zero.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= take_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_box(m_tdata);
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_vertex(coord_t x, coord_t y, coord_t z, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    board.note_vertex(x, y, z, last);
    vertices_sent++;
    @(negedge clk);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3: return coord_t'($urandom_range(2048) - 1024);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_mesh(int count);
    for (int i = 0; i < count; i++)
      send_vertex(pick_coord(), pick_coord(), pick_coord(), i == count - 1);
  endtask

  initial begin
    int mesh_len;
    int phase;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single-vertex meshes: zero extents, center twice the vertex.
    send_vertex('0, '0, '0, 1'b1);
    send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
    send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
    // Full-range box gives the largest extents and radius.
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_vertex(-24'sd1, 24'sd1, -24'sd256, 1'b0);
    send_vertex(24'sd1, -24'sd1, 24'sd256, 1'b0);
    send_vertex('0, '0, '0, 1'b1);
    send_mesh(5);

    vertices_sent = 0;
    while (vertices_sent < RANDOM_VERTICES) begin
      phase = vertices_sent * 4 / RANDOM_VERTICES;
      case (phase)
        0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
        1: begin send_idle_pct = 75; take_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  take_stall_pct = 75; end
        default: begin send_idle_pct = 28; take_stall_pct = 28; end
      endcase
      mesh_len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      send_mesh(mesh_len);
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (board.boxes_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
